// ----- design/rhm_pkg.sv -----
// shared types and constants for the roi histogram mode block
`timescale 1ns / 1ps

package rhm_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 12;
	localparam int BOUND_W    = 13;
	localparam int COUNT_W    = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_END   = 2'd3;

	localparam logic [BOUND_W-1:0] BOUND_RESET = 13'd4096;

	typedef enum logic [1:0] {
		ST_PIX,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic pix_take;
		logic scan_rd;
		logic load_out;
		logic clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage

// ----- design/roi_histogram_mode.sv -----
// top level of the region-of-interest gray-level histogram and mode finder
`timescale 1ns / 1ps

// usage
//  pixels enter on the input channel (in_valid / in_stall) with their row,
//  column and a last_pixel flag; a pixel inside the region of interest is
//  counted into the bin of its gray level, one pixel per cycle outside a scan
//  bins are a single-port-write memory, read registered; back-to-back hits
//  on the same bin are forwarded from the write path, so intake is one word
//  per clock with no bubbles until a scan stalls it
//  the word flagged last starts a scan: the block stalls its input while it
//  reads the bins one per cycle, then passes a drain state for the last compare
//  and a finish state for the hand-off, and then places one word with
//  mode_value and mode_count on the output channel (out_valid / out_stall);
//  lowest gray level wins on ties
//  the result sits in an output register, so the next frame's pixels are
//  taken while it waits; a second scan holds at its end until the receiver
//  lifts out_stall
//  the four region bounds go over the cfg channel, always ready; the user must
//  write them only while the block is idle, unenforced; end bounds exclusive
//  reset (arst_n low) clears the bins through per-bin valid bits, so there is
//  no clearing pass, and sets the region to the full 4096 x 4096 image

module roi_histogram_mode #(
	parameter int BIN_COUNT = 256,
	parameter int MAX_ROWS  = 4096,
	parameter int MAX_COLS  = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// pixel input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rhm_pkg::PIX_W-1:0]      pixel_value,
	input  logic [rhm_pkg::COORD_W-1:0]    row,
	input  logic [rhm_pkg::COORD_W-1:0]    col,
	input  logic                           last_pixel,
	// result output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rhm_pkg::PIX_W-1:0]      mode_value,
	output logic [rhm_pkg::COUNT_W-1:0]    mode_count,
	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rhm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rhm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rhm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// writes go straight into the region registers, so the port never holds off
	assign cfg_ready = 1'b1;

	rhm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_pixel (last_pixel),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	rhm_datapath #(
		.BIN_COUNT (BIN_COUNT),
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_value (pixel_value),
		.row         (row),
		.col         (col),
		.cmd         (cmd),
		.sts         (sts),
		.mode_value  (mode_value),
		.mode_count  (mode_count)
	);

endmodule

// ----- design/rhm_ctrl.sv -----
// sequencer for pixel intake, bin scan and result hand-off
`timescale 1ns / 1ps

module rhm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_pixel,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output rhm_pkg::cmd_t cmd,
	input  rhm_pkg::sts_t sts
);
	import rhm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PIX;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_PIX: begin
				in_stall     = 1'b0;
				cmd.pix_take = in_valid;
				if (in_valid && last_pixel) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_PIX;
				end
			end
			default: begin
				state_d = ST_PIX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- design/rhm_datapath.sv -----
// region registers, bin memory with increment path, and mode scan
`timescale 1ns / 1ps

module rhm_datapath #(
	parameter int BIN_COUNT = 256,
	parameter int MAX_ROWS  = 4096,
	parameter int MAX_COLS  = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rhm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rhm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [rhm_pkg::PIX_W-1:0]         pixel_value,
	input  logic [rhm_pkg::COORD_W-1:0]       row,
	input  logic [rhm_pkg::COORD_W-1:0]       col,
	input  rhm_pkg::cmd_t                     cmd,
	output rhm_pkg::sts_t                     sts,
	output logic [rhm_pkg::PIX_W-1:0]         mode_value,
	output logic [rhm_pkg::COUNT_W-1:0]       mode_count
);
	import rhm_pkg::*;

	localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

	logic [COORD_W-1:0] row_start_q, col_start_q;
	logic [BOUND_W-1:0] row_end_q, col_end_q;

	logic [COUNT_W-1:0] mem [BIN_COUNT];
	logic [BIN_COUNT-1:0] vld_q;

	logic [BIN_W-1:0]   scan_cnt_q;
	logic [BIN_W-1:0]   rd_addr;
	logic               in_roi;
	logic               counted;

	logic [BIN_W-1:0]   addr_s1;
	logic               inc_en_s1;
	logic               cmp_en_s1;
	logic               byp_s1;
	logic               zero_s1;
	logic [COUNT_W-1:0] byp_data_s1;
	logic [COUNT_W-1:0] mem_s1;
	logic [COUNT_W-1:0] rd_data;
	logic [COUNT_W-1:0] wr_data;

	logic [COUNT_W-1:0] best_count_q;
	logic [BIN_W-1:0]   best_bin_q;
	logic [PIX_W-1:0]   mode_value_q;
	logic [COUNT_W-1:0] mode_count_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_start_q <= '0;
			row_end_q   <= BOUND_RESET;
			col_start_q <= '0;
			col_end_q   <= BOUND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_START: row_start_q <= cfg_data[COORD_W-1:0];
				CFG_ROW_END:   row_end_q   <= cfg_data[BOUND_W-1:0];
				CFG_COL_START: col_start_q <= cfg_data[COORD_W-1:0];
				CFG_COL_END:   col_end_q   <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_roi = (row >= row_start_q) && ({1'b0, row} < row_end_q) &&
	                (col >= col_start_q) && ({1'b0, col} < col_end_q) &&
	                (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
	assign counted = in_roi && (32'(pixel_value) < BIN_COUNT);

	assign rd_addr = cmd.scan_rd ? scan_cnt_q : BIN_W'(pixel_value);

	// read data with bypass of a write to the same bin in the same cycle
	assign rd_data = byp_s1 ? byp_data_s1 : (zero_s1 ? '0 : mem_s1);
	assign wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

	always_ff @(posedge clk) begin
		if (inc_en_s1) begin
			mem[addr_s1] <= wr_data;
		end
		mem_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		addr_s1     <= rd_addr;
		byp_s1      <= inc_en_s1 && (addr_s1 == rd_addr);
		byp_data_s1 <= wr_data;
		zero_s1     <= !vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_en_s1 <= 1'b0;
			cmp_en_s1 <= 1'b0;
		end else begin
			inc_en_s1 <= cmd.pix_take && counted;
			cmp_en_s1 <= cmd.scan_rd;
		end
	end

	// an entry without its valid bit reads as an empty bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clear) begin
			vld_q <= '0;
		end else if (inc_en_s1) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	assign sts.scan_last = (scan_cnt_q == LAST_BIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
		end else if (cmd.clear) begin
			scan_cnt_q <= '0;
		end else if (cmd.scan_rd) begin
			scan_cnt_q <= sts.scan_last ? '0 : scan_cnt_q + 1'b1;
		end
	end

	// strict compare keeps the lowest bin on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_count_q <= '0;
			best_bin_q   <= '0;
		end else if (cmd.clear) begin
			best_count_q <= '0;
			best_bin_q   <= '0;
		end else if (cmp_en_s1 && (rd_data > best_count_q)) begin
			best_count_q <= rd_data;
			best_bin_q   <= addr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mode_value_q <= PIX_W'(best_bin_q);
			mode_count_q <= best_count_q;
		end
	end

	assign mode_value = mode_value_q;
	assign mode_count = mode_count_q;

endmodule
